### hdl/ppc_pkg.sv
package ppc_pkg;

  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 32;
  localparam int PAGE_W     = 20;
  localparam int WIN_W      = 21;

  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PERM_NONE     = 2'd0,
    PERM_RESERVED = 2'd1,
    PERM_USABLE   = 2'd2,
    PERM_UNUSED   = 2'd3
  } perm_t;

  localparam logic [CFG_IDX_W-1:0] REG_USER_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USER_HIGH = 2'd1;

  localparam logic [WIN_W-1:0] USER_LOW_RESET  = 21'd262144;
  localparam logic [WIN_W-1:0] USER_HIGH_RESET = 21'd983040;

  // One region as kept in the table memory; the end address is folded in at load.
  typedef struct packed {
    logic              usable;
    logic [ADDR_W-1:0] end_addr;
    logic [ADDR_W-1:0] start;
  } region_entry_t;

  typedef struct packed {
    logic hit;
    logic usable;
  } region_match_t;

endpackage

### hdl/ppc_region_table.sv
module ppc_region_table #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  ppc_pkg::region_entry_t        wr_entry,
  input  logic [ADDR_W-1:0]             rd_addr,
  input  logic [ppc_pkg::ADDR_W-1:0]    page_lo,
  input  logic [ppc_pkg::ADDR_W-1:0]    page_hi,
  output ppc_pkg::region_match_t        match
);
  import ppc_pkg::*;

  region_entry_t mem [DEPTH];
  region_entry_t rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_data <= mem[rd_addr];
  end

  // Region holds the whole page when it starts at or below the page and ends at or above it.
  always_comb begin
    match.hit    = (rd_data.start <= page_lo) && (rd_data.end_addr >= page_hi);
    match.usable = rd_data.usable;
  end

endmodule

### hdl/page_permission_classifier.sv
// Load and clear ops complete at the transfer; the block stays ready for the next input.
// A query outside the user window skips the scan and goes straight to its result; inside,
// it scans the table one entry per cycle through the single read port, and the result loads
// after a hit or after the last stored entry. Input is ready again as the result loads;
// a result still waiting on the output holds the next one back.
// Reset empties the table (no clearing pass), zeroes page count and overflow, restores window.
module page_permission_classifier #(
  parameter int MAX_REGIONS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // region_start[31:0], region_length[63:32], region_usable[64], page_index[84:65]
  input  logic [ppc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // op[1:0]
  input  logic [ppc_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // permission[1:0], page_count[21:2], in_range[22], overflow[23]
  output logic [ppc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppc_pkg::WIN_W-1:0]          cfg_data
);
  import ppc_pkg::*;

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int AW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_REGIONS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  state_t state;

  // Input field unpacking.
  op_t               in_op;
  logic [ADDR_W-1:0] in_start;
  logic [ADDR_W-1:0] in_length;
  logic              in_usable;
  logic [PAGE_W-1:0] in_page;

  assign in_op     = op_t'(s_axis_tuser[1:0]);
  assign in_start  = s_axis_tdata[31:0];
  assign in_length = s_axis_tdata[63:32];
  assign in_usable = s_axis_tdata[64];
  assign in_page   = s_axis_tdata[84:65];

  logic in_xfer;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Configuration registers: window bounds, taken at any time.
  logic [WIN_W-1:0] user_low;
  logic [WIN_W-1:0] user_high;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      user_low  <= USER_LOW_RESET;
      user_high <= USER_HIGH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_USER_LOW:  user_low  <= cfg_data;
        REG_USER_HIGH: user_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Load path: fold the end address and page count at the transfer.
  logic [CNT_W-1:0]  entry_count;
  logic [PAGE_W-1:0] max_pages;
  logic              overflow_seen;

  logic [ADDR_W-1:0] load_end;
  logic [ADDR_W-1:0] load_top;
  logic [PAGE_W-1:0] load_pages;
  logic              table_full;
  logic              load_xfer;
  logic              wr_en;
  region_entry_t     wr_entry;

  assign load_end   = in_start + in_length;
  assign load_top   = load_end + ADDR_W'(1);
  assign load_pages = load_top[ADDR_W-1:PAGE_SHIFT];
  assign table_full = (entry_count == FULL_COUNT);
  assign load_xfer  = in_xfer && (in_op == OP_LOAD);
  assign wr_en      = load_xfer && !table_full;

  always_comb begin
    wr_entry.usable   = in_usable;
    wr_entry.end_addr = load_end;
    wr_entry.start    = in_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      max_pages     <= '0;
      overflow_seen <= 1'b0;
    end else if (in_xfer) begin
      case (in_op)
        OP_LOAD: begin
          if (table_full) begin
            overflow_seen <= 1'b1;
          end else begin
            entry_count <= entry_count + CNT_W'(1);
            if (load_pages > max_pages) begin
              max_pages <= load_pages;
            end
          end
        end
        OP_CLEAR: begin
          entry_count <= '0;
          max_pages   <= '0;
        end
        default: ;
      endcase
    end
  end

  // Query path: hold the page and its byte bounds for the scan.
  logic [PAGE_W-1:0] q_page;
  logic [PAGE_W-1:0] q_page_inc;
  logic [ADDR_W-1:0] page_lo;
  logic [ADDR_W-1:0] page_hi;
  logic              outside_window;

  assign q_page_inc     = q_page + PAGE_W'(1);
  assign page_lo        = {q_page, {PAGE_SHIFT{1'b0}}};
  assign page_hi        = {q_page_inc, {PAGE_SHIFT{1'b0}}};
  assign outside_window = ({1'b0, in_page} < user_low) || ({1'b0, in_page} >= user_high);

  logic [CNT_W-1:0] idx;
  logic             chk_valid;
  region_match_t    match;

  ppc_region_table #(
    .DEPTH  (MAX_REGIONS),
    .ADDR_W (AW)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (entry_count[AW-1:0]),
    .wr_entry (wr_entry),
    .rd_addr  (idx[AW-1:0]),
    .page_lo  (page_lo),
    .page_hi  (page_hi),
    .match    (match)
  );

  perm_t             perm;
  perm_t             out_perm;
  logic [PAGE_W-1:0] out_pages;
  logic              out_in_range;
  logic              out_overflow;
  logic              out_free;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Sequencer: issue one table read per cycle and check the entry read the cycle before.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      idx           <= '0;
      chk_valid     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Drop the transferred result unless a new one loads this cycle.
      if (m_axis_tvalid && m_axis_tready && (state != ST_RESULT)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer && (in_op == OP_QUERY)) begin
            q_page    <= in_page;
            idx       <= '0;
            chk_valid <= 1'b0;
            if (outside_window) begin
              perm  <= PERM_RESERVED;
              state <= ST_RESULT;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (chk_valid && match.hit) begin
            perm      <= match.usable ? PERM_USABLE : PERM_NONE;
            chk_valid <= 1'b0;
            state     <= ST_RESULT;
          end else if (idx == entry_count) begin
            // Last stored entry checked without a hit.
            perm      <= PERM_NONE;
            chk_valid <= 1'b0;
            state     <= ST_RESULT;
          end else begin
            idx       <= idx + CNT_W'(1);
            chk_valid <= 1'b1;
          end
        end
        ST_RESULT: begin
          // Hold the result until the output register frees up.
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            out_perm      <= perm;
            out_pages     <= max_pages;
            out_in_range  <= (q_page < max_pages);
            out_overflow  <= overflow_seen;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {out_overflow, out_in_range, out_pages, out_perm};

  // Table never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= FULL_COUNT)
    else $error("entry count above capacity");

  // Scan index stays within the stored entries.
  a_scan_idx: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (idx <= entry_count))
    else $error("scan index past entry count");

  // A dropped load leaves the table alone and marks overflow.
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (load_xfer && table_full) |=> (overflow_seen && (entry_count == FULL_COUNT)))
    else $error("load into full table not dropped");

  // Overflow flag only falls on reset.
  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |=> overflow_seen)
    else $error("overflow flag cleared");

  // No permission code beyond usable ever reaches the output.
  a_perm_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_perm != PERM_UNUSED))
    else $error("bad permission code on output");

endmodule
